// ===== rtl/core/utf8_to_cp437_glyph_decoder_assert.svh =====
// Assertion macros for the UTF-8 to CP437 glyph decoder.
// Expects clk and arst_n in the scope of each use; NO_ASSERTIONS drops them.
`ifndef UTF8_TO_CP437_GLYPH_DECODER_ASSERT_SVH
`define UTF8_TO_CP437_GLYPH_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define U2C_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define U2C_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U2C_ASSERT(lbl, prop, msg)
`define U2C_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/u2c437_pkg.sv =====
// Shared types, lead byte codes and glyph lookup tables for the decoder.
// No dependencies.
package u2c437_pkg;

	localparam logic [7:0] LEAD_E2 = 8'hE2;
	localparam logic [7:0] LEAD_C2 = 8'hC2;
	localparam logic [7:0] LEAD_C3 = 8'hC3;
	localparam logic [7:0] LEAD_CE = 8'hCE;
	localparam logic [7:0] LEAD_CF = 8'hCF;
	localparam logic [7:0] GLYPH_UNKNOWN = 8'd1;
	localparam logic [7:0] GLYPH_NONE = 8'd0;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_LEAD   = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_end;
	} item_t;

	typedef struct packed {
		logic [7:0] glyph;
		logic       malformed;
	} result_t;

	typedef struct packed {
		logic    emit;
		result_t res;
	} decode_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] glyph;
	} pair_hit_t;

	function automatic logic is_lead(input logic [7:0] b);
		return b inside {LEAD_E2, LEAD_C2, LEAD_C3, LEAD_CE, LEAD_CF};
	endfunction

	// two-byte sequences, keyed on lead and second byte
	function automatic pair_hit_t pair_lookup(input logic [7:0] lead, input logic [7:0] sec);
		pair_hit_t r;
		r.hit = 1'b1;
		case ({lead, sec})
			16'hC2B6: r.glyph = 8'd20;   16'hC2A7: r.glyph = 8'd21;
			16'hC2A2: r.glyph = 8'd155;  16'hC2A3: r.glyph = 8'd156;
			16'hC2A5: r.glyph = 8'd157;  16'hC2AA: r.glyph = 8'd166;
			16'hC2BA: r.glyph = 8'd167;  16'hC2BF: r.glyph = 8'd168;
			16'hC2AC: r.glyph = 8'd170;  16'hC2BD: r.glyph = 8'd171;
			16'hC2BC: r.glyph = 8'd172;  16'hC2A1: r.glyph = 8'd173;
			16'hC2AB: r.glyph = 8'd174;  16'hC2BB: r.glyph = 8'd175;
			16'hC2B5: r.glyph = 8'd230;  16'hC2B1: r.glyph = 8'd241;
			16'hC2B0: r.glyph = 8'd248;  16'hC2B7: r.glyph = 8'd250;
			16'hC2B2: r.glyph = 8'd253;  16'hC2A0: r.glyph = 8'd255;
			16'hC387: r.glyph = 8'd128;  16'hC3BC: r.glyph = 8'd129;
			16'hC3A9: r.glyph = 8'd130;  16'hC3A2: r.glyph = 8'd131;
			16'hC3A4: r.glyph = 8'd132;  16'hC3A0: r.glyph = 8'd133;
			16'hC3A5: r.glyph = 8'd134;  16'hC3A7: r.glyph = 8'd135;
			16'hC3AA: r.glyph = 8'd136;  16'hC3AB: r.glyph = 8'd137;
			16'hC3A8: r.glyph = 8'd138;  16'hC3AF: r.glyph = 8'd139;
			16'hC3AE: r.glyph = 8'd140;  16'hC3AC: r.glyph = 8'd141;
			16'hC384: r.glyph = 8'd142;  16'hC385: r.glyph = 8'd143;
			16'hC389: r.glyph = 8'd144;  16'hC3A6: r.glyph = 8'd145;
			16'hC386: r.glyph = 8'd146;  16'hC3B4: r.glyph = 8'd147;
			16'hC3B6: r.glyph = 8'd148;  16'hC3B2: r.glyph = 8'd149;
			16'hC3BB: r.glyph = 8'd150;  16'hC3B9: r.glyph = 8'd151;
			16'hC3BF: r.glyph = 8'd152;  16'hC396: r.glyph = 8'd153;
			16'hC39C: r.glyph = 8'd154;  16'hC3A1: r.glyph = 8'd160;
			16'hC3AD: r.glyph = 8'd161;  16'hC3B3: r.glyph = 8'd162;
			16'hC3BA: r.glyph = 8'd163;  16'hC3B1: r.glyph = 8'd164;
			16'hC391: r.glyph = 8'd165;  16'hC39F: r.glyph = 8'd225;
			16'hC3B7: r.glyph = 8'd246;
			16'hC692: r.glyph = 8'd159;  // C6 never leads, kept for completeness
			16'hCEB1: r.glyph = 8'd224;  16'hCE93: r.glyph = 8'd226;
			16'hCEA3: r.glyph = 8'd228;  16'hCEA6: r.glyph = 8'd232;
			16'hCE98: r.glyph = 8'd233;  16'hCEA9: r.glyph = 8'd234;
			16'hCEB4: r.glyph = 8'd235;  16'hCEB5: r.glyph = 8'd238;
			16'hCF80: r.glyph = 8'd227;  16'hCF83: r.glyph = 8'd229;
			16'hCF84: r.glyph = 8'd231;  16'hCF86: r.glyph = 8'd237;
			default: begin
				r.hit   = 1'b0;
				r.glyph = GLYPH_NONE;
			end
		endcase
		return r;
	endfunction

	// three-byte sequences, keyed on second and third byte only
	function automatic logic [7:0] triple_lookup(input logic [7:0] sec, input logic [7:0] thd);
		logic [7:0] g;
		case ({sec, thd})
			16'h98BA: g = 8'd1;    16'h98BB: g = 8'd2;    16'h98BC: g = 8'd15;
			16'h99A5: g = 8'd3;    16'h99A6: g = 8'd4;    16'h99A3: g = 8'd5;
			16'h99A0: g = 8'd6;    16'h9982: g = 8'd11;   16'h9980: g = 8'd12;
			16'h99AA: g = 8'd13;   16'h99AB: g = 8'd14;
			16'h80A2: g = 8'd7;    16'h80BC: g = 8'd19;
			16'h9798: g = 8'd8;    16'h978B: g = 8'd9;    16'h9799: g = 8'd10;
			16'h9784: g = 8'd17;
			16'h96BA: g = 8'd16;   16'h96AC: g = 8'd22;   16'h96B2: g = 8'd30;
			16'h96BC: g = 8'd31;   16'h9691: g = 8'd176;  16'h9692: g = 8'd177;
			16'h9693: g = 8'd178;  16'h9688: g = 8'd219;  16'h9684: g = 8'd220;
			16'h968C: g = 8'd221;  16'h9690: g = 8'd222;  16'h9680: g = 8'd223;
			16'h96A0: g = 8'd254;
			16'h8695: g = 8'd18;   16'h86A8: g = 8'd23;   16'h8691: g = 8'd24;
			16'h8693: g = 8'd25;   16'h8692: g = 8'd26;   16'h8690: g = 8'd27;
			16'h8694: g = 8'd29;
			16'h889F: g = 8'd28;   16'h889E: g = 8'd236;  16'h88A9: g = 8'd239;
			16'h8899: g = 8'd249;  16'h889A: g = 8'd251;
			16'h8C82: g = 8'd127;  16'h8C90: g = 8'd169;  16'h8CA0: g = 8'd244;
			16'h8CA1: g = 8'd245;
			16'h82A7: g = 8'd158;
			16'h9482: g = 8'd179;  16'h94A4: g = 8'd180;  16'h9490: g = 8'd191;
			16'h9494: g = 8'd192;  16'h94B4: g = 8'd193;  16'h94AC: g = 8'd194;
			16'h949C: g = 8'd195;  16'h9480: g = 8'd196;  16'h94BC: g = 8'd197;
			16'h9498: g = 8'd217;  16'h948C: g = 8'd218;
			16'h95A1: g = 8'd181;  16'h95A2: g = 8'd182;  16'h9596: g = 8'd183;
			16'h9595: g = 8'd184;  16'h95A3: g = 8'd185;  16'h9591: g = 8'd186;
			16'h9597: g = 8'd187;  16'h959D: g = 8'd188;  16'h959C: g = 8'd189;
			16'h959B: g = 8'd190;  16'h959E: g = 8'd198;  16'h959F: g = 8'd199;
			16'h959A: g = 8'd200;  16'h9594: g = 8'd201;  16'h95A9: g = 8'd202;
			16'h95A6: g = 8'd203;  16'h95A0: g = 8'd204;  16'h9590: g = 8'd205;
			16'h95AC: g = 8'd206;  16'h95A7: g = 8'd207;  16'h95A8: g = 8'd208;
			16'h95A4: g = 8'd209;  16'h95A5: g = 8'd210;  16'h9599: g = 8'd211;
			16'h9598: g = 8'd212;  16'h9592: g = 8'd213;  16'h9593: g = 8'd214;
			16'h95AB: g = 8'd215;  16'h95AA: g = 8'd216;
			16'h89A1: g = 8'd240;  16'h89A5: g = 8'd242;  16'h89A4: g = 8'd243;
			16'h8988: g = 8'd247;
			16'h81BF: g = 8'd252;
			default:  g = GLYPH_UNKNOWN;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/core/u2c437_in_if.sv =====
// Input channel of the decoder: one text byte per item plus end-of-string flag.
// No dependencies.
interface u2c437_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_end;

	modport source (output valid, in_byte, text_end, input ready);
	modport sink   (input valid, in_byte, text_end, output ready);
endinterface

// ===== rtl/core/u2c437_out_if.sv =====
// Output channel of the decoder: one CP437 glyph code per item.
// No dependencies.
interface u2c437_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] glyph;
	logic       malformed;

	modport source (output valid, glyph, malformed, input ready);
	modport sink   (input valid, glyph, malformed, output ready);
endinterface

// ===== rtl/core/utf8_to_cp437_glyph_decoder.sv =====
// Top level of the UTF-8 to code page 437 glyph decoder.
// Depends on u2c437_pkg, u2c437_in_if, u2c437_out_if and the three stage modules.
//
//   channel  dir  payload                       items
//   text     in   in_byte[7:0], text_end        one byte of UTF-8 text
//   glyphs   out  glyph[7:0], malformed         zero or one per input byte
//
// One byte is taken every clock while the glyph output drains; the rate is set by
// the single decode stage between the input register and the result register.
// Each accepted byte is held in the input register until its glyph is registered.
// Lead bytes, and a second byte that does not complete a pair, give no item
// unless the string ends on them.
// Reset (arst_n low) empties both registers and returns the phase to idle.
// A full result register that is not taken holds the decode stage, and the
// input then takes no new byte once stage 1 is occupied.
`include "utf8_to_cp437_glyph_decoder_assert.svh"

module utf8_to_cp437_glyph_decoder (
	input  logic          clk,
	input  logic          arst_n,
	u2c437_in_if.sink     text,
	u2c437_out_if.source  glyphs
);

	logic                 valid_s1;
	u2c437_pkg::item_t    item_s1;
	logic                 advance;
	logic                 out_free;
	logic                 out_load;
	u2c437_pkg::decode_t  dec;
	u2c437_pkg::phase_t   phase;

	// stage 1 moves on only when the result register can take its outcome
	assign advance  = valid_s1 && out_free;
	assign out_load = advance && dec.emit;

	u2c437_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	u2c437_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.dec     (dec),
		.phase   (phase)
	);

	u2c437_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.glyphs (glyphs),
		.load   (out_load),
		.res    (dec.res),
		.free   (out_free)
	);

	// a malformed item carries glyph zero
	`U2C_ASSERT_ALWAYS(a_malformed_zero,
		(glyphs.valid && glyphs.malformed) |-> (glyphs.glyph == u2c437_pkg::GLYPH_NONE),
		"malformed item with nonzero glyph")
	// malformed is only raised by the last byte of a string
	`U2C_ASSERT(a_malformed_at_end,
		(out_load && dec.res.malformed) |-> item_s1.text_end,
		"malformed result without end of text")
	// a held stage-1 item stays put
	`U2C_ASSERT(a_s1_hold,
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)),
		"stage 1 item lost while stalled")
	// the third byte always closes the sequence
	`U2C_ASSERT(a_third_closes,
		(advance && phase == u2c437_pkg::PH_SECOND) |=> (phase == u2c437_pkg::PH_IDLE),
		"phase not idle after third byte")

endmodule

// ===== rtl/core/u2c437_in_stage.sv =====
// Input register stage: captures one byte item and holds it until decoded.
// Depends on u2c437_pkg and u2c437_in_if.
module u2c437_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	u2c437_in_if.sink             text,
	input  logic                  advance,
	output logic                  valid_s1,
	output u2c437_pkg::item_t     item_s1
);

	logic take;

	assign text.ready = !valid_s1 || advance;
	assign take       = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.in_byte  <= text.in_byte;
			item_s1.text_end <= text.text_end;
		end
	end

endmodule

// ===== rtl/core/u2c437_decode.sv =====
// Sequence decoder: phase state machine, held lead/second bytes, table lookups.
// Depends on u2c437_pkg.
module u2c437_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  u2c437_pkg::item_t     item_s1,
	output u2c437_pkg::decode_t   dec,
	output u2c437_pkg::phase_t    phase
);

	u2c437_pkg::phase_t    phase_q, phase_d;
	logic [7:0]            lead_q, second_q;
	u2c437_pkg::pair_hit_t pair;
	logic                  lead_in;

	assign pair    = u2c437_pkg::pair_lookup(lead_q, item_s1.in_byte);
	assign lead_in = u2c437_pkg::is_lead(item_s1.in_byte);
	assign phase   = phase_q;

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			u2c437_pkg::PH_LEAD: begin
				if (pair.hit || item_s1.text_end) phase_d = u2c437_pkg::PH_IDLE;
				else phase_d = u2c437_pkg::PH_SECOND;
			end
			u2c437_pkg::PH_SECOND: begin
				phase_d = u2c437_pkg::PH_IDLE;
			end
			default: begin
				// idle, and the unused code
				if (lead_in && !item_s1.text_end) phase_d = u2c437_pkg::PH_LEAD;
				else phase_d = u2c437_pkg::PH_IDLE;
			end
		endcase
	end

	// result for the item in stage 1
	always_comb begin
		dec.emit          = 1'b1;
		dec.res.glyph     = u2c437_pkg::GLYPH_NONE;
		dec.res.malformed = 1'b0;
		case (phase_q)
			u2c437_pkg::PH_LEAD: begin
				if (pair.hit) begin
					dec.res.glyph = pair.glyph;
				end else if (item_s1.text_end) begin
					dec.res.malformed = 1'b1;
				end else begin
					dec.emit = 1'b0;
				end
			end
			u2c437_pkg::PH_SECOND: begin
				dec.res.glyph = u2c437_pkg::triple_lookup(second_q, item_s1.in_byte);
			end
			default: begin
				if (!lead_in) begin
					dec.res.glyph = item_s1.in_byte;
				end else if (item_s1.text_end) begin
					dec.res.malformed = 1'b1;
				end else begin
					dec.emit = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= u2c437_pkg::PH_IDLE;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	// each held byte is read only in the phase after the one that wrote it
	always_ff @(posedge clk) begin
		if (advance) begin
			if (phase_q != u2c437_pkg::PH_LEAD && phase_q != u2c437_pkg::PH_SECOND) begin
				lead_q <= item_s1.in_byte;
			end
			if (phase_q == u2c437_pkg::PH_LEAD) begin
				second_q <= item_s1.in_byte;
			end
		end
	end

endmodule

// ===== rtl/core/u2c437_out_stage.sv =====
// Result register: holds one glyph item until the sink takes it.
// Depends on u2c437_pkg and u2c437_out_if.
module u2c437_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	u2c437_out_if.source          glyphs,
	input  logic                  load,
	input  u2c437_pkg::result_t   res,
	output logic                  free
);

	logic                valid_q;
	u2c437_pkg::result_t res_q;

	assign free             = !valid_q || glyphs.ready;
	assign glyphs.valid     = valid_q;
	assign glyphs.glyph     = res_q.glyph;
	assign glyphs.malformed = res_q.malformed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (glyphs.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== tb/sv/u2c437_glyph_scoreboard_pkg.sv =====
// Glyph scoreboard for the UTF-8 to CP437 decoder bench: lookup tables, decode predictor, checker.
// Depends on u2c437_pkg for the item and result types, the phase codes and the lead byte codes.
`timescale 1ns / 100ps

package u2c437_glyph_scoreboard_pkg;
	import u2c437_pkg::*;

	localparam int PAIR_N   = 68;
	localparam int TRIPLE_N = 92;

	// {lead, second, glyph} per entry
	localparam logic [PAIR_N*24-1:0] PAIR_MAP = {
		16'hC2B6, 8'd20,  16'hC2A7, 8'd21,  16'hC2A2, 8'd155, 16'hC2A3, 8'd156,
		16'hC2A5, 8'd157, 16'hC2AA, 8'd166, 16'hC2BA, 8'd167, 16'hC2BF, 8'd168,
		16'hC2AC, 8'd170, 16'hC2BD, 8'd171, 16'hC2BC, 8'd172, 16'hC2A1, 8'd173,
		16'hC2AB, 8'd174, 16'hC2BB, 8'd175, 16'hC2B5, 8'd230, 16'hC2B1, 8'd241,
		16'hC2B0, 8'd248, 16'hC2B7, 8'd250, 16'hC2B2, 8'd253, 16'hC2A0, 8'd255,
		16'hC387, 8'd128, 16'hC3BC, 8'd129, 16'hC3A9, 8'd130, 16'hC3A2, 8'd131,
		16'hC3A4, 8'd132, 16'hC3A0, 8'd133, 16'hC3A5, 8'd134, 16'hC3A7, 8'd135,
		16'hC3AA, 8'd136, 16'hC3AB, 8'd137, 16'hC3A8, 8'd138, 16'hC3AF, 8'd139,
		16'hC3AE, 8'd140, 16'hC3AC, 8'd141, 16'hC384, 8'd142, 16'hC385, 8'd143,
		16'hC389, 8'd144, 16'hC3A6, 8'd145, 16'hC386, 8'd146, 16'hC3B4, 8'd147,
		16'hC3B6, 8'd148, 16'hC3B2, 8'd149, 16'hC3BB, 8'd150, 16'hC3B9, 8'd151,
		16'hC3BF, 8'd152, 16'hC396, 8'd153, 16'hC39C, 8'd154, 16'hC3A1, 8'd160,
		16'hC3AD, 8'd161, 16'hC3B3, 8'd162, 16'hC3BA, 8'd163, 16'hC3B1, 8'd164,
		16'hC391, 8'd165, 16'hC39F, 8'd225, 16'hC3B7, 8'd246,
		16'hC692, 8'd159,
		16'hCEB1, 8'd224, 16'hCE93, 8'd226, 16'hCEA3, 8'd228, 16'hCEA6, 8'd232,
		16'hCE98, 8'd233, 16'hCEA9, 8'd234, 16'hCEB4, 8'd235, 16'hCEB5, 8'd238,
		16'hCF80, 8'd227, 16'hCF83, 8'd229, 16'hCF84, 8'd231, 16'hCF86, 8'd237
	};

	// {second, third, glyph} per entry; the lead byte plays no part
	localparam logic [TRIPLE_N*24-1:0] TRIPLE_MAP = {
		16'h98BA, 8'd1,   16'h98BB, 8'd2,   16'h98BC, 8'd15,
		16'h99A5, 8'd3,   16'h99A6, 8'd4,   16'h99A3, 8'd5,   16'h99A0, 8'd6,
		16'h9982, 8'd11,  16'h9980, 8'd12,  16'h99AA, 8'd13,  16'h99AB, 8'd14,
		16'h80A2, 8'd7,   16'h80BC, 8'd19,
		16'h9798, 8'd8,   16'h978B, 8'd9,   16'h9799, 8'd10,  16'h9784, 8'd17,
		16'h96BA, 8'd16,  16'h96AC, 8'd22,  16'h96B2, 8'd30,  16'h96BC, 8'd31,
		16'h9691, 8'd176, 16'h9692, 8'd177, 16'h9693, 8'd178, 16'h9688, 8'd219,
		16'h9684, 8'd220, 16'h968C, 8'd221, 16'h9690, 8'd222, 16'h9680, 8'd223,
		16'h96A0, 8'd254,
		16'h8695, 8'd18,  16'h86A8, 8'd23,  16'h8691, 8'd24,  16'h8693, 8'd25,
		16'h8692, 8'd26,  16'h8690, 8'd27,  16'h8694, 8'd29,
		16'h889F, 8'd28,  16'h889E, 8'd236, 16'h88A9, 8'd239, 16'h8899, 8'd249,
		16'h889A, 8'd251,
		16'h8C82, 8'd127, 16'h8C90, 8'd169, 16'h8CA0, 8'd244, 16'h8CA1, 8'd245,
		16'h82A7, 8'd158,
		16'h9482, 8'd179, 16'h94A4, 8'd180, 16'h9490, 8'd191, 16'h9494, 8'd192,
		16'h94B4, 8'd193, 16'h94AC, 8'd194, 16'h949C, 8'd195, 16'h9480, 8'd196,
		16'h94BC, 8'd197, 16'h9498, 8'd217, 16'h948C, 8'd218,
		16'h95A1, 8'd181, 16'h95A2, 8'd182, 16'h9596, 8'd183, 16'h9595, 8'd184,
		16'h95A3, 8'd185, 16'h9591, 8'd186, 16'h9597, 8'd187, 16'h959D, 8'd188,
		16'h959C, 8'd189, 16'h959B, 8'd190, 16'h959E, 8'd198, 16'h959F, 8'd199,
		16'h959A, 8'd200, 16'h9594, 8'd201, 16'h95A9, 8'd202, 16'h95A6, 8'd203,
		16'h95A0, 8'd204, 16'h9590, 8'd205, 16'h95AC, 8'd206, 16'h95A7, 8'd207,
		16'h95A8, 8'd208, 16'h95A4, 8'd209, 16'h95A5, 8'd210, 16'h9599, 8'd211,
		16'h9598, 8'd212, 16'h9592, 8'd213, 16'h9593, 8'd214, 16'h95AB, 8'd215,
		16'h95AA, 8'd216,
		16'h89A1, 8'd240, 16'h89A5, 8'd242, 16'h89A4, 8'd243, 16'h8988, 8'd247,
		16'h81BF, 8'd252
	};

	function automatic logic [23:0] pair_entry(int i);
		return PAIR_MAP[i*24 +: 24];
	endfunction

	function automatic logic [23:0] triple_entry(int i);
		return TRIPLE_MAP[i*24 +: 24];
	endfunction

	// C6 is deliberately absent: it passes through
	function automatic bit starts_sequence(logic [7:0] b);
		return b == LEAD_E2 || b == LEAD_C2 || b == LEAD_C3 || b == LEAD_CE || b == LEAD_CF;
	endfunction

	class glyph_scoreboard;
		phase_t      phase;
		logic [7:0]  lead_byte;
		logic [7:0]  held_second;
		result_t     expected_glyphs[$];
		int unsigned failures;
		int unsigned glyphs_seen;

		function new();
			phase       = PH_IDLE;
			lead_byte   = 8'h00;
			held_second = 8'h00;
			failures    = 0;
			glyphs_seen = 0;
		endfunction

		function bit pair_glyph(logic [7:0] lead, logic [7:0] sec, output logic [7:0] g);
			logic [23:0] e;
			g = GLYPH_NONE;
			for (int i = 0; i < PAIR_N; i++) begin
				e = pair_entry(i);
				if (e[23:8] == {lead, sec}) begin
					g = e[7:0];
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function logic [7:0] triple_glyph(logic [7:0] sec, logic [7:0] thd);
			logic [23:0] e;
			for (int i = 0; i < TRIPLE_N; i++) begin
				e = triple_entry(i);
				if (e[23:8] == {sec, thd})
					return e[7:0];
			end
			return GLYPH_UNKNOWN;
		endfunction

		// every result also ends the sequence in hand
		function void emit_glyph(logic [7:0] g, logic bad);
			result_t r;
			r.glyph     = g;
			r.malformed = bad;
			expected_glyphs.push_back(r);
			phase       = PH_IDLE;
			lead_byte   = 8'h00;
			held_second = 8'h00;
		endfunction

		function void note_byte(item_t it);
			logic [7:0] g;
			case (phase)
				PH_LEAD: begin
					if (pair_glyph(lead_byte, it.in_byte, g))
						emit_glyph(g, 1'b0);
					else if (it.text_end)
						emit_glyph(GLYPH_NONE, 1'b1);
					else begin
						held_second = it.in_byte;
						phase       = PH_SECOND;
					end
				end
				PH_SECOND: emit_glyph(triple_glyph(held_second, it.in_byte), 1'b0);
				default: begin
					if (!starts_sequence(it.in_byte))
						emit_glyph(it.in_byte, 1'b0);
					else if (it.text_end)
						emit_glyph(GLYPH_NONE, 1'b1);
					else begin
						lead_byte   = it.in_byte;
						held_second = 8'h00;
						phase       = PH_LEAD;
					end
				end
			endcase
		endfunction

		function void check_glyph(result_t got);
			result_t want;
			glyphs_seen++;
			if (expected_glyphs.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] glyph %0d unexpected: glyph %0d malformed %0b",
						$time, glyphs_seen, got.glyph, got.malformed);
				return;
			end
			want = expected_glyphs.pop_front();
			if (got.glyph !== want.glyph || got.malformed !== want.malformed) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] glyph %0d mismatch: want %0d/%0b, got %0d/%0b",
						$time, glyphs_seen, want.glyph, want.malformed,
						got.glyph, got.malformed);
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_utf8_to_cp437_glyph_decoder.sv =====
// Bench top for utf8_to_cp437_glyph_decoder: directed and random UTF-8 text, random idling, checking.
// Depends on u2c437_pkg, both channel interfaces, the decoder RTL and u2c437_glyph_scoreboard_pkg.
`timescale 1ns / 100ps

module tb_utf8_to_cp437_glyph_decoder;
	import u2c437_pkg::*;
	import u2c437_glyph_scoreboard_pkg::*;

	localparam int RANDOM_BYTES = 1350;

	logic  clk;
	logic  arst_n;
	logic  hold_off;        // receiver back-pressure window
	item_t text_plan[$];    // every byte to be offered, in order

	glyph_scoreboard sb = new();

	u2c437_in_if  text_ch ();
	u2c437_out_if glyph_ch ();

	utf8_to_cp437_glyph_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.glyphs (glyph_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void plan_byte(logic [7:0] b, logic last);
		item_t it;
		it.in_byte  = b;
		it.text_end = last;
		text_plan.push_back(it);
	endfunction

	function automatic logic [7:0] any_lead();
		case ($urandom_range(0, 4))
			0:       return LEAD_E2;
			1:       return LEAD_C2;
			2:       return LEAD_C3;
			3:       return LEAD_CE;
			default: return LEAD_CF;
		endcase
	endfunction

	// Directed opening: pass-through, every lead, pair hits, three-byte hits and
	// misses, and each way the text can end mid-sequence.
	function automatic void plan_directed();
		plan_byte(8'hFF, 1'b1);                        // top byte, last of its string
		plan_byte(8'hC6, 1'b0); plan_byte(8'h92, 1'b0); // C6 is no lead: both pass through
		plan_byte(LEAD_C2, 1'b0); plan_byte(8'hA0, 1'b0);
		plan_byte(LEAD_C3, 1'b0); plan_byte(8'h87, 1'b0);
		plan_byte(LEAD_E2, 1'b0); plan_byte(8'h98, 1'b0); plan_byte(8'hBA, 1'b0);
		// unknown three-byte sequence gives the fallback glyph
		plan_byte(LEAD_E2, 1'b0); plan_byte(8'h00, 1'b0); plan_byte(8'h00, 1'b0);
		// two-byte lead, no pair, so a third byte is looked up without the lead
		plan_byte(LEAD_CE, 1'b0); plan_byte(8'h99, 1'b0); plan_byte(8'hA5, 1'b0);
		// string ends on a lead byte
		plan_byte(LEAD_CF, 1'b1);
		plan_byte(LEAD_C2, 1'b1);
		// string ends on a second byte that matches no pair
		plan_byte(LEAD_E2, 1'b0); plan_byte(8'h95, 1'b1);
		// pair hit on the last byte is a normal glyph
		plan_byte(LEAD_C2, 1'b0); plan_byte(8'hB0, 1'b1);
		// a third byte always gives its glyph, end flag or not
		plan_byte(LEAD_E2, 1'b0); plan_byte(8'h95, 1'b0); plan_byte(8'h90, 1'b1);
	endfunction

	// Random text: mostly well-formed sequences with random content, the rest noise
	// (stray leads, strings cut short, random bytes).
	function automatic void plan_random(int unsigned total);
		int unsigned kind;
		int unsigned noise_len;
		logic [23:0] e;
		logic [7:0]  b;
		while (text_plan.size() < total) begin
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				do b = 8'($urandom_range(0, 255)); while (starts_sequence(b));
				plan_byte(b, $urandom_range(0, 7) == 0);
			end else if (kind < 45) begin
				e = pair_entry($urandom_range(0, PAIR_N - 1));
				plan_byte(e[23:16], 1'b0);
				plan_byte(e[15:8], $urandom_range(0, 7) == 0);
			end else if (kind < 75) begin
				e = triple_entry($urandom_range(0, TRIPLE_N - 1));
				plan_byte(LEAD_E2, 1'b0);
				plan_byte(e[23:16], 1'b0);
				plan_byte(e[15:8], $urandom_range(0, 7) == 0);
			end else if (kind < 85) begin
				// any lead with a triple body; the odd one hits a pair instead
				e = triple_entry($urandom_range(0, TRIPLE_N - 1));
				plan_byte(any_lead(), 1'b0);
				plan_byte(e[23:16], 1'b0);
				plan_byte(e[15:8], 1'($urandom_range(0, 1)));
			end else begin
				noise_len = $urandom_range(1, 3);
				repeat (noise_len) begin
					b = $urandom_range(0, 1) ? any_lead() : 8'($urandom_range(0, 255));
					plan_byte(b, $urandom_range(0, 3) == 0);
				end
			end
		end
	endfunction

	// One item on the text channel. Valid is only lowered when a gap is drawn, so
	// back-to-back items never see two assignments to it in one step.
	task automatic offer_text_byte(item_t it, int unsigned n);
		int unsigned gap;
		gap = (n % 160 < 40) ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid    <= 1'b1;
		text_ch.in_byte  <= it.in_byte;
		text_ch.text_end <= it.text_end;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		sb.note_byte(it);
	endtask

	// Glyph receiver: random stall per item, quiet stretches, and the long
	// hold-off window on top of that.
	initial begin
		int unsigned gap;
		result_t     got;
		glyph_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (sb.glyphs_seen % 128 < 48) ? 0 : $urandom_range(0, 19);
			if (gap != 0 || hold_off) begin
				glyph_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			glyph_ch.ready <= 1'b1;
			@(posedge clk);
			while (!glyph_ch.valid) @(posedge clk);
			got.glyph     = glyph_ch.glyph;
			got.malformed = glyph_ch.malformed;
			sb.check_glyph(got);
		end
	end

	// Long receiver hold-off while the sender keeps offering, so the result
	// register and stage 1 fill and the input stalls.
	initial begin
		hold_off = 1'b0;
		wait (arst_n === 1'b1);
		repeat (2500) @(posedge clk);
		hold_off <= 1'b1;
		repeat (500) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog, far above the slowest legal run.
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		text_ch.valid    = 1'b0;
		text_ch.in_byte  = 8'h00;
		text_ch.text_end = 1'b0;
		plan_directed();
		plan_random(text_plan.size() + RANDOM_BYTES);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (text_plan[i])
			offer_text_byte(text_plan[i], i);
		text_ch.valid <= 1'b0;
		// drain, then idle before the verdict so any stray glyph still gets caught
		while (sb.expected_glyphs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
